/* hdl/fazb_pkg.sv */
// fazb_pkg: shared types and constants of the spare-zone lender
`default_nettype none

package fazb_pkg;

   // command codes
   localparam logic CMD_BORROW = 1'b0;
   localparam logic CMD_RETURN = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_MISSING = 2'd1;
   localparam logic [1:0] STAT_NOSPARE = 2'd2;
   localparam logic [1:0] STAT_REFUSED = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_ESS_POOL    = 2'd0;
   localparam logic [1:0] REG_SPARE_POOL  = 2'd1;
   localparam logic [1:0] REG_FRAG_LIMIT  = 2'd2;
   localparam logic [1:0] REG_CUT_FACTOR  = 2'd3;

   localparam logic [15:0] FRAG_LIMIT_RST = 16'd2048;
   localparam logic [8:0]  CUT_FACTOR_RST = 9'd128;

   // stripe sizing
   localparam logic [15:0] BASE_STRIPE = 16'd32768;
   localparam logic [15:0] MIN_STRIPE  = 16'd4096;
   localparam int          DIV_STEPS   = 16;
   localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);

   // estimate: floor((spare*4096 + 50) / 100) via reciprocal ceil(2^30 / 100)
   localparam logic [21:0] EST_ROUND   = 22'd50;
   localparam logic [23:0] RECIP_100   = 24'd10737419;
   localparam int          RECIP_SHIFT = 30;

   typedef struct packed {
      logic        command;
      logic [1:0]  tenant;
      logic [9:0]  want_width;
      logic        vzone_found;
      logic [15:0] frag_ratio;
      logic [9:0]  give_back;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        frag_cut;
      logic [10:0] granted_width;
      logic [9:0]  granted_essential;
      logic [9:0]  granted_spare;
      logic [15:0] stripe_bytes;
      logic [15:0] frag_estimate;
      logic [9:0]  spares_in_use;
   } rsp_word_type;

   typedef struct packed {
      logic [9:0]  ess_pool;
      logic [9:0]  spare_pool;
      logic [15:0] frag_limit;
      logic [8:0]  cut_factor;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic decide;
      logic div_step;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic early_done;
   } dp_stat_type;

endpackage

`default_nettype wire

/* hdl/frag_aware_zone_borrow_top.sv */
// frag_aware_zone_borrow_top: spare-zone lender with fragmentation check
// sequence: accept, prep and decide, then the result strobe for return, refused, vzone
//   missing or no-spare words; a grant goes on from decide through the bit-serial stripe divider and finish
// throughput: one word at a time; the next start is taken in the cycle of the strobe
// the receiver cannot stall: rsp_valid is high for exactly one cycle per word
// reset (synchronous, active high) clears lending state and tenant records and
//   returns the registers to their defaults
`default_nettype none

module frag_aware_zone_borrow_top #(
   parameter int TENANTS   = 4,
   parameter int MIN_WIDTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  fazb_pkg::req_word_type  req_word,
   // result channel
   output logic                    rsp_valid,
   output fazb_pkg::rsp_word_type  rsp_word,
   // configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   fazb_pkg::cfg_type      cfg;
   fazb_pkg::ctrl_cmd_type cmd;
   fazb_pkg::dp_stat_type  stat;

   // register file: essential pool, spare pool, frag limit, cut factor
   fazb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: idle, prep, decide, divide, finish
   fazb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // grant math, per-tenant tallies and the stripe divider
   fazb_dp #(
      .TENANTS   (TENANTS),
      .MIN_WIDTH (MIN_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cfg      (cfg),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

/* hdl/fazb_csr.sv */
// fazb_csr: configuration registers behind the apb-style port
`default_nettype none

module fazb_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready,
   output fazb_pkg::cfg_type     cfg
);

   fazb_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ess_pool   <= '0;
         cfg_ff.spare_pool <= '0;
         cfg_ff.frag_limit <= fazb_pkg::FRAG_LIMIT_RST;
         cfg_ff.cut_factor <= fazb_pkg::CUT_FACTOR_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            fazb_pkg::REG_ESS_POOL:   cfg_ff.ess_pool   <= pwdata[9:0];
            fazb_pkg::REG_SPARE_POOL: cfg_ff.spare_pool <= pwdata[9:0];
            fazb_pkg::REG_FRAG_LIMIT: cfg_ff.frag_limit <= pwdata[15:0];
            fazb_pkg::REG_CUT_FACTOR: cfg_ff.cut_factor <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         fazb_pkg::REG_ESS_POOL:   prdata = {22'd0, cfg_ff.ess_pool};
         fazb_pkg::REG_SPARE_POOL: prdata = {22'd0, cfg_ff.spare_pool};
         fazb_pkg::REG_FRAG_LIMIT: prdata = {16'd0, cfg_ff.frag_limit};
         fazb_pkg::REG_CUT_FACTOR: prdata = {23'd0, cfg_ff.cut_factor};
         default:                  prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/fazb_ctrl.sv */
// fazb_ctrl: sequencing state machine of the lender
`default_nettype none

module fazb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output logic                    rsp_valid,
   output fazb_pkg::ctrl_cmd_type  cmd,
   input  fazb_pkg::dp_stat_type   stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DECIDE,
      S_DIV,
      S_FINISH
   } state_type;

   localparam logic [fazb_pkg::DIV_CNT_W-1:0] CNT_LAST =
      fazb_pkg::DIV_CNT_W'(fazb_pkg::DIV_STEPS - 1);

   state_type                      state_ff, state_in;
   logic [fazb_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                           done_ff, done_in;
   logic                           accept;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = done_ff;
   assign accept    = start & ~busy;

   always_comb begin
      cmd.load     = accept;
      cmd.prep     = (state_ff == S_PREP);
      cmd.decide   = (state_ff == S_DECIDE);
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_FINISH);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_PREP;
         end
         S_PREP: state_in = S_DECIDE;
         S_DECIDE: begin
            count_in = '0;
            if (stat.early_done) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_LAST) state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not make the block busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy)
      else $error("result strobe while still working");

endmodule

`default_nettype wire

/* hdl/fazb_dp.sv */
// fazb_dp: lending state, grant arithmetic and stripe divider
`default_nettype none

module fazb_dp #(
   parameter int TENANTS   = 4,
   parameter int MIN_WIDTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  fazb_pkg::req_word_type  req_word,
   input  fazb_pkg::cfg_type       cfg,
   input  fazb_pkg::ctrl_cmd_type  cmd,
   output fazb_pkg::dp_stat_type   stat,
   output fazb_pkg::rsp_word_type  rsp_word
);

   localparam int TIDX_W = (TENANTS > 1) ? $clog2(TENANTS) : 1;
   localparam int EPROD_W = 46;

   localparam logic [9:0] MINW = 10'(MIN_WIDTH);

   // captured request and prep results
   fazb_pkg::req_word_type req_ff;
   logic                   cut_ff;
   logic [9:0]             width_ff;
   logic [7:0]             ess_ff;
   logic [9:0]             avail_ff;

   // lending state
   logic [9:0]             lent_ff, lent_in;
   logic [9:0]             spares_ff [TENANTS];
   logic                   known_ff  [TENANTS];

   // grant and divider
   logic [10:0]            gw_ff;
   logic [9:0]             alloc_ff;
   logic [9:0]             half_ff;
   logic [15:0]            estq_ff;
   logic [15:0]            dvd_ff;
   logic [9:0]             rem_ff;
   logic [15:0]            quo_ff;

   fazb_pkg::rsp_word_type rsp_ff, rsp_in;

   // prep
   logic [17:0]            scale_prod;
   logic [9:0]             scaled;
   logic                   frag_hi;
   logic [9:0]             width_in;
   logic [7:0]             ess_raw, ess_in;
   logic [9:0]             avail_in;

   // decide
   logic [4:0]             tenant_x;
   logic                   in_range;
   logic [TIDX_W-1:0]      tidx;
   logic                   is_ret, missing, ret_ok, grant;
   logic [9:0]             req_sp, alloc;
   logic [9:0]             cur_spares;
   logic [10:0]            lent_sum, sp_sum, gw;
   logic [9:0]             sp_grant;
   logic [21:0]            est_num;
   logic [EPROD_W-1:0]     est_prod;

   // divider step
   logic [10:0]            rem_sh, rem_diff;
   logic                   rem_ge;

   // finish
   logic [16:0]            est_sum;

   assign rsp_word = rsp_ff;

   // ---------------- prep ----------------
   always_comb begin
      scale_prod = 18'(req_ff.want_width) * 18'(cfg.cut_factor);
      scaled     = scale_prod[17:8];
      frag_hi    = req_ff.frag_ratio > cfg.frag_limit;
      if (frag_hi) width_in = (scaled < MINW) ? MINW : scaled;
      else         width_in = req_ff.want_width;
      ess_raw    = cfg.ess_pool[9:2];
      ess_in     = (ess_raw == 8'd0) ? 8'd1 : ess_raw;
      avail_in   = (cfg.spare_pool > lent_ff) ? cfg.spare_pool - lent_ff : 10'd0;
   end

   // ---------------- decide ----------------
   always_comb begin
      tenant_x   = {3'd0, req_ff.tenant};
      in_range   = tenant_x < 5'(TENANTS);
      tidx       = tenant_x[TIDX_W-1:0];
      cur_spares = spares_ff[tidx];
      is_ret     = (req_ff.command == fazb_pkg::CMD_RETURN);
      missing    = ~in_range | ~req_ff.vzone_found;
      ret_ok     = in_range && known_ff[tidx] && !(cur_spares < req_ff.give_back);
      req_sp     = (width_ff > 10'(ess_ff)) ? width_ff - 10'(ess_ff) : 10'd0;
      alloc      = (req_sp < avail_ff) ? req_sp : avail_ff;
      grant      = ~is_ret & ~missing & (alloc != 10'd0);
      stat.early_done = ~grant;

      lent_sum   = 11'(lent_ff) + 11'(alloc);
      sp_sum     = 11'(cur_spares) + 11'(alloc);
      sp_grant   = sp_sum[10] ? 10'd1023 : sp_sum[9:0];
      gw         = 11'(ess_ff) + 11'(alloc);
      est_num    = {alloc, 12'd0} + fazb_pkg::EST_ROUND;
      est_prod   = EPROD_W'(est_num) * EPROD_W'(fazb_pkg::RECIP_100);

      lent_in = lent_ff;
      if (cmd.decide) begin
         if (is_ret && ret_ok) begin
            lent_in = (lent_ff >= req_ff.give_back) ? lent_ff - req_ff.give_back : 10'd0;
         end else if (grant) begin
            lent_in = lent_sum[10] ? 10'd1023 : lent_sum[9:0];
         end
      end
   end

   // ---------------- divider step ----------------
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[15]};
      rem_diff = rem_sh - {1'b0, half_ff};
      rem_ge   = rem_sh >= {1'b0, half_ff};
   end

   // ---------------- result word ----------------
   always_comb begin
      est_sum = 17'(req_ff.frag_ratio) + 17'(estq_ff);
      rsp_in  = '0;
      rsp_in.spares_in_use = lent_in;
      if (cmd.finish) begin
         rsp_in.status            = fazb_pkg::STAT_OK;
         rsp_in.frag_cut          = cut_ff;
         rsp_in.granted_width     = gw_ff;
         rsp_in.granted_essential = 10'(ess_ff);
         rsp_in.granted_spare     = alloc_ff;
         rsp_in.stripe_bytes      = (quo_ff < fazb_pkg::MIN_STRIPE) ?
                                    fazb_pkg::MIN_STRIPE : quo_ff;
         rsp_in.frag_estimate     = est_sum[16] ? 16'hFFFF : est_sum[15:0];
      end else if (is_ret) begin
         rsp_in.status = ret_ok ? fazb_pkg::STAT_OK : fazb_pkg::STAT_REFUSED;
      end else if (missing) begin
         rsp_in.status = fazb_pkg::STAT_MISSING;
      end else begin
         // no spare could be granted
         rsp_in.status   = fazb_pkg::STAT_NOSPARE;
         rsp_in.frag_cut = cut_ff;
      end
   end

   // ---------------- lending state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         lent_ff <= '0;
         for (int i = 0; i < TENANTS; i++) begin
            spares_ff[i] <= '0;
            known_ff[i]  <= 1'b0;
         end
      end else begin
         lent_ff <= lent_in;
         if (cmd.decide && is_ret && ret_ok) begin
            spares_ff[tidx] <= cur_spares - req_ff.give_back;
         end else if (cmd.decide && grant) begin
            spares_ff[tidx] <= sp_grant;
            known_ff[tidx]  <= 1'b1;
         end
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
      if (cmd.prep) begin
         cut_ff   <= frag_hi;
         width_ff <= width_in;
         ess_ff   <= ess_in;
         avail_ff <= avail_in;
      end
      if (cmd.decide) begin
         gw_ff    <= gw;
         alloc_ff <= alloc;
         half_ff  <= gw[10:1];
         estq_ff  <= est_prod[fazb_pkg::RECIP_SHIFT +: 16];
         dvd_ff   <= fazb_pkg::BASE_STRIPE;
         rem_ff   <= '0;
         quo_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_diff[9:0] : rem_sh[9:0];
         quo_ff <= {quo_ff[14:0], rem_ge};
         dvd_ff <= {dvd_ff[14:0], 1'b0};
      end
      if ((cmd.decide && ~grant) || cmd.finish) rsp_ff <= rsp_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (half_ff != 10'd0))
      else $error("stripe divider running with a zero divisor");

   a_grant_lent: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (lent_ff >= alloc_ff) && (alloc_ff != 10'd0))
      else $error("granted spares not reflected in spares lent");

endmodule

`default_nettype wire

/* verif/tb.sv */
// tb: self-checking testbench of the spare-zone lender with fragmentation check
`timescale 1ns / 100ps

module tb;

   // watchdog: cycles with no accepted word, no result and no register write
   localparam int STALL_LIMIT = 2000;
   // quiet cycles after the last result before a register write or the end
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 155;

   logic                   clock    = 1'b0;
   logic                   reset    = 1'b1;
   logic                   start    = 1'b0;
   fazb_pkg::req_word_type req_word = '0;
   logic                   psel     = 1'b0;
   logic                   penable  = 1'b0;
   logic                   pwrite   = 1'b0;
   logic [3:0]             paddr    = '0;
   logic [31:0]            pwdata   = '0;
   wire                    busy;
   wire                    rsp_valid;
   fazb_pkg::rsp_word_type rsp_word;
   wire [31:0]             prdata;
   wire                    pready;

   frag_aware_zone_borrow_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // command words waiting to be sent, and result words still owed by the block
   fazb_pkg::req_word_type cmd_backlog[$];
   fazb_pkg::rsp_word_type due_words[$];
   int errors = 0;

   // shadow of the registers, as written through the configuration port
   int unsigned cfg_ess_pool   = 0;
   int unsigned cfg_spare_pool = 0;
   int unsigned cfg_frag_limit = 32'(fazb_pkg::FRAG_LIMIT_RST);
   int unsigned cfg_cut_factor = 32'(fazb_pkg::CUT_FACTOR_RST);

   // shadow of the lending state
   int unsigned lent_total = 0;
   int unsigned held_spares[4] = '{default: 0};
   int unsigned held_ess[4]    = '{default: 0};
   bit          held_known[4]  = '{default: 0};

   // work out the result word of one command and advance the shadow state
   function automatic fazb_pkg::rsp_word_type lend_outcome(fazb_pkg::req_word_type w);
      fazb_pkg::rsp_word_type r;
      int unsigned width, ess, avail, ask, alloc, gw, half, stripe, est;
      r = '0;
      if (w.command == fazb_pkg::CMD_RETURN) begin
         if (!held_known[w.tenant] || held_spares[w.tenant] < w.give_back) begin
            r.status = fazb_pkg::STAT_REFUSED;
         end else begin
            held_spares[w.tenant] -= w.give_back;
            lent_total = (lent_total >= w.give_back) ? lent_total - w.give_back : 0;
            r.status = fazb_pkg::STAT_OK;
         end
      end else if (!w.vzone_found) begin
         r.status = fazb_pkg::STAT_MISSING;
      end else begin
         width = 32'(w.want_width);
         // too fragmented: scale the width down, never below the minimum width
         if (w.frag_ratio > cfg_frag_limit) begin
            width = (width * cfg_cut_factor) >> 8;
            if (width < 2) width = 2;
            r.frag_cut = 1'b1;
         end
         ess = cfg_ess_pool / 4;
         if (ess < 1) ess = 1;
         // spare pool lowered below what is lent out leaves nothing free
         avail = (cfg_spare_pool > lent_total) ? cfg_spare_pool - lent_total : 0;
         // a width under the essential share asks for no spares at all
         ask = (width > ess) ? width - ess : 0;
         alloc = (ask < avail) ? ask : avail;
         if (alloc == 0) begin
            r.status = fazb_pkg::STAT_NOSPARE;
         end else begin
            lent_total += alloc;
            if (lent_total > 1023) lent_total = 1023;
            held_spares[w.tenant] += alloc;
            if (held_spares[w.tenant] > 1023) held_spares[w.tenant] = 1023;
            held_ess[w.tenant] += ess;
            if (held_ess[w.tenant] > 65535) held_ess[w.tenant] = 65535;
            held_known[w.tenant] = 1'b1;
            gw = ess + alloc;
            half = gw / 2;
            stripe = (half != 0) ? 32768 / half : 32768;
            if (stripe < 4096) stripe = 4096;
            // about 0.01 per spare in Q4.12, rounded half up, saturating
            est = w.frag_ratio + (alloc * 4096 + 50) / 100;
            if (est > 65535) est = 65535;
            r.status            = fazb_pkg::STAT_OK;
            r.granted_width     = 11'(gw);
            r.granted_essential = 10'(ess);
            r.granted_spare     = 10'(alloc);
            r.stripe_bytes      = 16'(stripe);
            r.frag_estimate     = 16'(est);
         end
      end
      r.spares_in_use = 10'(lent_total);
      return r;
   endfunction

   // command builders: fields a command does not use get random filler
   function automatic void queue_borrow(int t, int want, int found, int frag);
      fazb_pkg::req_word_type w;
      w.command     = fazb_pkg::CMD_BORROW;
      w.tenant      = 2'(t);
      w.want_width  = 10'(want);
      w.vzone_found = 1'(found);
      w.frag_ratio  = 16'(frag);
      w.give_back   = 10'($urandom);
      cmd_backlog   = {cmd_backlog, w};
   endfunction

   function automatic void queue_return(int t, int back);
      fazb_pkg::req_word_type w;
      w.command     = fazb_pkg::CMD_RETURN;
      w.tenant      = 2'(t);
      w.want_width  = 10'($urandom);
      w.vzone_found = 1'($urandom);
      w.frag_ratio  = 16'($urandom);
      w.give_back   = 10'(back);
      cmd_backlog   = {cmd_backlog, w};
   endfunction

   // mostly well-formed borrows and returns, with the fragmentation often
   // right at the threshold and sizes mostly small
   function automatic void queue_random();
      int frag, want, back;
      if ($urandom_range(0, 99) < 55) begin
         want = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 64) : $urandom_range(0, 1023);
         case ($urandom_range(0, 2))
            0: frag = $urandom_range(0, 65535);
            1: frag = $urandom_range(0, 8191);
            default: begin
               frag = int'(cfg_frag_limit) + $urandom_range(0, 2) - 1;
               if (frag < 0) frag = 0;
               if (frag > 65535) frag = 65535;
            end
         endcase
         queue_borrow($urandom_range(0, 3), want, ($urandom_range(0, 9) != 0), frag);
      end else begin
         back = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
         queue_return($urandom_range(0, 3), back);
      end
   endfunction

   // one register write: setup cycle, access cycle, written at the edge ending it
   task automatic csr_write(logic [1:0] idx, int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         fazb_pkg::REG_ESS_POOL:   cfg_ess_pool   = value & 32'h3FF;
         fazb_pkg::REG_SPARE_POOL: cfg_spare_pool = value & 32'h3FF;
         fazb_pkg::REG_FRAG_LIMIT: cfg_frag_limit = value & 32'hFFFF;
         fazb_pkg::REG_CUT_FACTOR: cfg_cut_factor = value & 32'h1FF;
         default: ;
      endcase
   endtask

   task automatic apply_config(int unsigned ess, int unsigned spare, int unsigned lim,
                               int unsigned cut);
      csr_write(fazb_pkg::REG_ESS_POOL, ess);
      csr_write(fazb_pkg::REG_SPARE_POOL, spare);
      csr_write(fazb_pkg::REG_FRAG_LIMIT, lim);
      csr_write(fazb_pkg::REG_CUT_FACTOR, cut);
      // step off the rising edge before touching the backlog
      @(negedge clock);
   endtask

   // wait until every command is sent and answered, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || start || due_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // driver: bursts of random length with random gaps, start held until taken
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (start && !busy) begin
            due_words = {due_words, lend_outcome(req_word)};
            void'(cmd_backlog.pop_front());
         end
         // a word still waiting for the block stays on the port untouched
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               start    <= 1'b1;
               req_word <= cmd_backlog[0];
               burst_left--;
               if (burst_left <= 0) begin
                  // now and then a long run with no idling at all
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         errors++;
      end
   endtask

   // monitor: every strobed word is matched against the oldest one owed
   always @(posedge clock) begin
      fazb_pkg::rsp_word_type exp;
      if (!reset && rsp_valid) begin
         if (due_words.size() == 0) begin
            $error("result word with nothing expected: status %0d", rsp_word.status);
            errors++;
         end else begin
            exp = due_words.pop_front();
            check_field("status", 32'(exp.status), 32'(rsp_word.status));
            check_field("frag_cut", 32'(exp.frag_cut), 32'(rsp_word.frag_cut));
            check_field("granted_width", 32'(exp.granted_width),
                        32'(rsp_word.granted_width));
            check_field("granted_essential", 32'(exp.granted_essential),
                        32'(rsp_word.granted_essential));
            check_field("granted_spare", 32'(exp.granted_spare),
                        32'(rsp_word.granted_spare));
            check_field("stripe_bytes", 32'(exp.stripe_bytes),
                        32'(rsp_word.stripe_bytes));
            check_field("frag_estimate", 32'(exp.frag_estimate),
                        32'(rsp_word.frag_estimate));
            check_field("spares_in_use", 32'(exp.spares_in_use),
                        32'(rsp_word.spares_in_use));
         end
      end
   end

   // watchdog: too long without any traffic means the block is stuck
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pwrite)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("** frag_aware_zone_borrow_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: essential share 10, 100 spares, reset threshold and factor
      apply_config(40, 100, 32'(fazb_pkg::FRAG_LIMIT_RST), 32'(fazb_pkg::CUT_FACTOR_RST));
      queue_borrow(0, 20, 0, 0);          // vzone missing
      queue_borrow(0, 0, 1, 0);           // zero width
      queue_borrow(0, 10, 1, 0);          // width equal to the essential share
      queue_return(1, 0);                 // tenant that never borrowed
      queue_borrow(0, 20, 1, 0);          // plain grant, stripe at its floor
      queue_borrow(1, 30, 1, 2048);       // fragmentation right at the threshold
      queue_borrow(1, 30, 1, 2049);       // just above it: width halved
      queue_borrow(2, 12, 1, 65535);      // cut below the essential share
      queue_return(0, 11);                // more than the tenant holds
      queue_return(0, 0);
      queue_return(0, 4);
      queue_borrow(3, 1023, 1, 0);        // limited by the free spares
      queue_borrow(2, 50, 1, 0);          // nothing left to lend
      queue_return(3, 69);
      queue_return(1, 1023);
      queue_borrow(2, 1023, 1, 65535);
      queue_return(2, 69);
      queue_return(1, 25);
      queue_return(0, 6);
      settle();

      // essential share floored at one, every spare free, no cut possible
      apply_config(0, 1023, 65535, 256);
      queue_borrow(0, 1023, 1, 65535);    // estimate saturates
      queue_borrow(1, 3, 1, 0);
      queue_return(0, 1022);
      settle();

      // threshold zero and factor zero: every width falls to the minimum
      apply_config(0, 1023, 0, 0);
      queue_borrow(2, 500, 1, 1);
      queue_borrow(3, 1023, 1, 65535);
      settle();

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 6)
            0: apply_config(0, 1023, 65535, 256);
            1: apply_config(1023, 0, 0, 0);
            2: apply_config(20, 200, 2048, 128);
            3: apply_config($urandom_range(0, 1023), 10, $urandom_range(0, 65535),
                            $urandom_range(0, 256));
            4: apply_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 65535), $urandom_range(0, 256));
            default: apply_config(4, 1023, 4096, 64);
         endcase
         repeat (PHASE_WORDS) queue_random();
         settle();
      end

      if (due_words.size() != 0) begin
         $error("%0d result words never arrived", due_words.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** frag_aware_zone_borrow_top: PASSED **");
      end else begin
         $display("** frag_aware_zone_borrow_top: FAILED **");
      end
      $finish;
   end

endmodule
